@@ rtl/skt_pkg.sv @@
package skt_pkg;

  // Field widths of the command and result ports
  localparam int unsigned CMD_W  = 3;
  localparam int unsigned KEY_W  = 31;
  localparam int unsigned YEAR_W = 14;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned POS_W  = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 3'd0,
    CMD_LOOKUP = 3'd1,
    CMD_RANK   = 3'd2,
    CMD_REMOVE = 3'd3,
    CMD_DUMP   = 3'd4
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK   = 2'd0,
    ST_DUP  = 2'd1,
    ST_MISS = 2'd2,
    ST_FULL = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_EXEC,
    S_SHIFT_UP,
    S_INS_WR,
    S_SHIFT_DN,
    S_DUMP
  } state_e;

  // One table entry as held in the RAM
  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [YEAR_W-1:0] year;
  } entry_t;

endpackage

@@ rtl/skt_ram.sv @@
module skt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

@@ rtl/sorted_key_table.sv @@
// Channel  | Ports                                      | Dir | Transfer
// ---------+--------------------------------------------+-----+----------------------------
// command  | command_i, key_i, year_i                   | in  | start && !busy at clk edge
// result   | status_o, key_out_o, year_out_o,           | out | result_valid_o, one cycle
//          | position_o, last_o                         |     |
//
// Every command but dump walks the entries through the RAM's single read port
// with one key comparator and stops at the first key not below its own. Insert
// and remove then move the tail from that slot one entry a cycle, so scan and
// shift together pass each entry once; dump streams one entry a cycle.
// Reset clears the state, the entry count and the pending and valid flags;
// the RAM holds no reset value. The receiver cannot stall results; the last
// one shows in the same cycle that busy drops.
module sorted_key_table
  import skt_pkg::*;
#(
  parameter int unsigned CAPACITY = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [CMD_W-1:0]    command_i,
  input  logic [KEY_W-1:0]    key_i,
  input  logic [YEAR_W-1:0]   year_i,
  output logic                result_valid_o,
  output logic [STAT_W-1:0]   status_o,
  output logic [KEY_W-1:0]    key_out_o,
  output logic [YEAR_W-1:0]   year_out_o,
  output logic [POS_W-1:0]    position_o,
  output logic                last_o
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned EW = $bits(entry_t);

  state_e            state_q, state_d;
  cmd_e              cmd_q, cmd_d;
  logic [KEY_W-1:0]  key_q, key_d;
  logic [YEAR_W-1:0] year_q, year_d;
  logic [CW-1:0]     count_q, count_d;
  logic [CW-1:0]     idx_q, idx_d;
  logic [CW-1:0]     pidx_q, pidx_d;
  logic              pend_q, pend_d;
  logic [CW-1:0]     pos_q, pos_d;
  logic              hit_q, hit_d;
  logic [YEAR_W-1:0] hyear_q, hyear_d;

  logic              rvalid_q, rvalid_d;
  status_e           status_q, status_d;
  logic [KEY_W-1:0]  kout_q, kout_d;
  logic [YEAR_W-1:0] yout_q, yout_d;
  logic [POS_W-1:0]  posout_q, posout_d;
  logic              last_q, last_d;

  logic              rd_en, wr_en;
  logic [AW-1:0]     rd_addr, wr_addr;
  entry_t            wr_data, rd_data;
  logic              issue;
  logic [CW-1:0]     idx_dec;

  assign idx_dec = idx_q - CW'(1);

  skt_ram #(
    .WIDTH (EW),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      pend_q   <= 1'b0;
      rvalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      pend_q   <= pend_d;
      rvalid_q <= rvalid_d;
    end
  end

  // Payload and working registers
  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    key_q    <= key_d;
    year_q   <= year_d;
    idx_q    <= idx_d;
    pidx_q   <= pidx_d;
    pos_q    <= pos_d;
    hit_q    <= hit_d;
    hyear_q  <= hyear_d;
    status_q <= status_d;
    kout_q   <= kout_d;
    yout_q   <= yout_d;
    posout_q <= posout_d;
    last_q   <= last_d;
  end

  // Sequencer: next state, RAM access and result load
  always_comb begin
    state_d  = state_q;
    cmd_d    = cmd_q;
    key_d    = key_q;
    year_d   = year_q;
    count_d  = count_q;
    idx_d    = idx_q;
    pidx_d   = pidx_q;
    pend_d   = 1'b0;
    pos_d    = pos_q;
    hit_d    = hit_q;
    hyear_d  = hyear_q;
    rvalid_d = 1'b0;
    status_d = ST_OK;
    kout_d   = key_q;
    yout_d   = '0;
    posout_d = '0;
    last_d   = 1'b1;
    rd_en    = 1'b0;
    rd_addr  = idx_q[AW-1:0];
    wr_en    = 1'b0;
    wr_addr  = pidx_q[AW-1:0];
    wr_data  = rd_data;
    issue    = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_d  = cmd_e'(command_i);
          key_d  = key_i;
          year_d = year_i;
          idx_d  = '0;
          unique case (cmd_e'(command_i))
            CMD_INSERT, CMD_LOOKUP, CMD_RANK, CMD_REMOVE: state_d = S_SCAN;
            CMD_DUMP:                                    state_d = S_DUMP;
            default:                                     state_d = S_IDLE;
          endcase
        end
      end

      // Lower-bound search, one compare per cycle behind the RAM read
      S_SCAN: begin
        issue   = (idx_q < count_q);
        rd_en   = issue;
        pend_d  = issue;
        pidx_d  = idx_q;
        if (issue) begin
          idx_d = idx_q + CW'(1);
        end
        priority if (pend_q && (rd_data.key >= key_q)) begin
          pos_d   = pidx_q;
          hit_d   = (rd_data.key == key_q);
          hyear_d = rd_data.year;
          pend_d  = 1'b0;
          state_d = S_EXEC;
        end else if (!pend_q && !issue) begin
          pos_d   = count_q;
          hit_d   = 1'b0;
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        state_d = S_IDLE;
        unique case (cmd_q)
          CMD_INSERT: begin
            priority if (hit_q) begin
              rvalid_d = 1'b1;
              status_d = ST_DUP;
            end else if (count_q == CW'(CAPACITY)) begin
              rvalid_d = 1'b1;
              status_d = ST_FULL;
            end else begin
              idx_d   = count_q;
              state_d = S_SHIFT_UP;
            end
          end
          CMD_LOOKUP: begin
            rvalid_d = 1'b1;
            status_d = hit_q ? ST_OK : ST_MISS;
            yout_d   = hit_q ? hyear_q : '0;
          end
          CMD_RANK: begin
            rvalid_d = 1'b1;
            status_d = hit_q ? ST_OK : ST_MISS;
            posout_d = hit_q ? (POS_W'(pos_q) + POS_W'(1)) : '0;
          end
          CMD_REMOVE: begin
            if (hit_q) begin
              idx_d   = pos_q + CW'(1);
              state_d = S_SHIFT_DN;
            end else begin
              rvalid_d = 1'b1;
              status_d = ST_MISS;
            end
          end
          default: state_d = S_IDLE;
        endcase
      end

      // Move entries pos..count-1 up one slot, top first
      S_SHIFT_UP: begin
        issue   = (idx_q > pos_q);
        rd_en   = issue;
        rd_addr = idx_dec[AW-1:0];
        pend_d  = issue;
        pidx_d  = idx_q;
        if (issue) begin
          idx_d = idx_dec;
        end
        if (pend_q) begin
          wr_en = 1'b1;
        end
        if (!issue && !pend_q) begin
          state_d = S_INS_WR;
        end
      end

      S_INS_WR: begin
        wr_en        = 1'b1;
        wr_addr      = pos_q[AW-1:0];
        wr_data.key  = key_q;
        wr_data.year = year_q;
        count_d      = count_q + CW'(1);
        rvalid_d     = 1'b1;
        status_d     = ST_OK;
        state_d      = S_IDLE;
      end

      // Move entries pos+1..count-1 down one slot, bottom first
      S_SHIFT_DN: begin
        issue  = (idx_q < count_q);
        rd_en  = issue;
        pend_d = issue;
        pidx_d = idx_dec;
        if (issue) begin
          idx_d = idx_q + CW'(1);
        end
        if (pend_q) begin
          wr_en = 1'b1;
        end
        if (!issue && !pend_q) begin
          count_d  = count_q - CW'(1);
          rvalid_d = 1'b1;
          status_d = ST_OK;
          state_d  = S_IDLE;
        end
      end

      // Stream the table out in order, one entry a cycle
      S_DUMP: begin
        if (count_q == '0) begin
          rvalid_d = 1'b1;
          status_d = ST_MISS;
          kout_d   = '0;
          state_d  = S_IDLE;
        end else begin
          issue  = (idx_q < count_q);
          rd_en  = issue;
          pend_d = issue;
          pidx_d = idx_q;
          if (issue) begin
            idx_d = idx_q + CW'(1);
          end
          if (pend_q) begin
            rvalid_d = 1'b1;
            status_d = ST_OK;
            kout_d   = rd_data.key;
            yout_d   = rd_data.year;
            last_d   = (pidx_q == idx_dec) && !issue;
            if (last_d) begin
              pend_d  = 1'b0;
              state_d = S_IDLE;
            end
          end
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = rvalid_q;
  assign status_o       = status_q;
  assign key_out_o      = kout_q;
  assign year_out_o     = yout_q;
  assign position_o     = posout_q;
  assign last_o         = last_q;

endmodule

@@ rtl/skt_checker.sv @@
module skt_checker
  import skt_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input logic [CMD_W-1:0]  command_i,
  input logic              result_valid_o,
  input logic [STAT_W-1:0] status_o,
  input logic [POS_W-1:0]  position_o,
  input logic              last_o
);

  // Error results are always single and final
  a_err_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (status_o != ST_OK) |-> last_o)
    else $error("error result without last");

  // A rank position only comes with a successful single result
  a_pos_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (position_o != '0) |-> (status_o == ST_OK) && last_o)
    else $error("position on a non-ok result");

  // Results only follow a cycle in which the block was working
  a_res_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy))
    else $error("result without a command in progress");

  // A valid command transfer makes the block busy
  a_go_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (command_i <= CMD_DUMP) |=> busy)
    else $error("command transfer did not start work");

  // An unknown command is dropped without any result
  a_bad_cmd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (command_i > CMD_DUMP) |=> !busy && !result_valid_o)
    else $error("unknown command was not ignored");

endmodule

bind sorted_key_table skt_checker u_skt_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .command_i      (command_i),
  .result_valid_o (result_valid_o),
  .status_o       (status_o),
  .position_o     (position_o),
  .last_o         (last_o)
);
